>>> hw/rtl/rcppm_pkg.sv
package rcppm_pkg;

  // Item kinds carried in the input tuser
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_RUN_ENABLE    = 2'd1,
    REG_SYNC_LENGTH   = 2'd2,
    REG_PULSE_WIDTH   = 2'd3
  } reg_index_e;

  localparam int unsigned CountW  = 5;
  localparam int unsigned SyncW   = 13;
  localparam int unsigned PulseW  = 10;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned SlotW   = 12;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned ValueW  = 16;

  localparam logic [CountW-1:0] CountReset = 5'd8;
  localparam logic [SyncW-1:0]  SyncReset  = 13'd4500;
  localparam logic [PulseW-1:0] PulseReset = 10'd300;
  localparam logic [SlotW-1:0]  SlotResetEven = 12'd1200;
  localparam logic [SlotW-1:0]  SlotResetOdd  = 12'd1500;
  localparam logic [ValueW-1:0] WriteMin      = 16'd800;

  // Settings that shape the timeline
  typedef struct packed {
    logic [CountW-1:0] channel_count;
    logic [SyncW-1:0]  sync_length;
    logic [PulseW-1:0] pulse_width;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic             frame_start;
    logic             write_accepted;
    logic [SlotW-1:0] read_value;
    logic             ppm_level;
  } result_t;

endpackage

>>> hw/rtl/rcppm_engine.sv
module rcppm_engine #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned SLOT_MAX     = 2200
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 item_en_i,
  input  rcppm_pkg::action_e                   action_i,
  input  logic [rcppm_pkg::IndexW-1:0]         channel_index_i,
  input  logic [rcppm_pkg::ValueW-1:0]         value_i,
  input  rcppm_pkg::cfg_t                      cfg_i,
  input  logic                                 run_i,
  input  logic                                 start_i,
  output rcppm_pkg::result_t                   result_o
);

  localparam int unsigned AddrW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned FrameW = 18;

  // Slot store and timeline state
  logic [rcppm_pkg::SlotW-1:0] store_q [MAX_CHANNELS];
  logic [rcppm_pkg::TimeW-1:0] tick_q, tick_d;
  logic [rcppm_pkg::TimeW-1:0] slot_len_q, slot_len_d;
  logic [rcppm_pkg::TimeW-1:0] used_q, used_d;
  logic [rcppm_pkg::CountW-1:0] next_ch_q, next_ch_d;
  logic                         pulse_on_q, pulse_on_d;
  logic                         in_sync_q, in_sync_d;

  logic [5:0]                   active;
  logic [rcppm_pkg::CountW-1:0] ch_base;
  logic [rcppm_pkg::TimeW-1:0]  used_base;
  logic                         chan_slot;
  logic [rcppm_pkg::TimeW:0]    tick_inc;
  logic                         slot_done;
  logic [31:0]                  ci_ext, ch_ext;
  logic [AddrW-1:0]             rd_addr, wr_addr;
  logic [rcppm_pkg::SlotW-1:0]  rd_data;
  logic [FrameW-1:0]            frame_full;
  logic [rcppm_pkg::TimeW-1:0]  frame_len, sync_slot;
  logic [rcppm_pkg::TimeW-1:0]  chan_len;
  logic                         do_tick, do_write, idx_in_store;

  // Effective channel count and slot bookkeeping
  assign active    = ({1'b0, cfg_i.channel_count} < 6'(MAX_CHANNELS))
                   ? {1'b0, cfg_i.channel_count} : 6'(MAX_CHANNELS);
  assign ch_base   = in_sync_q ? '0 : next_ch_q;
  assign used_base = in_sync_q ? '0 : used_q;
  assign chan_slot = {1'b0, ch_base} < active;
  assign tick_inc  = {1'b0, tick_q} + 17'd1;
  assign slot_done = tick_inc >= {1'b0, slot_len_q};

  // One read port: the read item or the next channel slot
  assign ci_ext  = 32'(channel_index_i);
  assign ch_ext  = 32'(ch_base);
  assign wr_addr = ci_ext[AddrW-1:0];
  assign rd_addr = (action_i == rcppm_pkg::ACT_READ) ? ci_ext[AddrW-1:0] : ch_ext[AddrW-1:0];
  assign rd_data = store_q[rd_addr];
  assign chan_len = (rd_data == '0) ? 16'd1 : {4'b0, rd_data};

  // Sync slot pads the frame to its budget
  assign frame_full = 18'(SLOT_MAX) * {12'b0, active} + {5'b0, cfg_i.sync_length};
  assign frame_len  = (frame_full > 18'h0FFFF) ? 16'hFFFF : frame_full[15:0];
  assign sync_slot  = (frame_len > used_base) ? (frame_len - used_base) : 16'd1;

  assign do_tick      = item_en_i && (action_i == rcppm_pkg::ACT_TICK) && run_i;
  assign idx_in_store = {2'b0, channel_index_i} < 6'(MAX_CHANNELS);
  assign do_write     = item_en_i && (action_i == rcppm_pkg::ACT_WRITE) && idx_in_store
                     && (value_i > rcppm_pkg::WriteMin) && (value_i < 16'(SLOT_MAX));

  // Advance the timeline
  always_comb begin
    tick_d     = tick_q;
    slot_len_d = slot_len_q;
    used_d     = used_q;
    next_ch_d  = next_ch_q;
    pulse_on_d = pulse_on_q;
    in_sync_d  = in_sync_q;
    if (start_i) begin
      tick_d     = '0;
      slot_len_d = (cfg_i.sync_length == '0) ? 16'd1 : {3'b0, cfg_i.sync_length};
      used_d     = '0;
      next_ch_d  = '0;
      pulse_on_d = 1'b0;
      in_sync_d  = 1'b1;
    end else if (do_tick) begin
      if (slot_done) begin
        tick_d     = '0;
        pulse_on_d = 1'b1;
        if (chan_slot) begin
          slot_len_d = chan_len;
          used_d     = used_base + {4'b0, rd_data};
          next_ch_d  = ch_base + 5'd1;
          in_sync_d  = 1'b0;
        end else begin
          slot_len_d = sync_slot;
          used_d     = used_base;
          next_ch_d  = ch_base;
          in_sync_d  = 1'b1;
        end
      end else begin
        tick_d = tick_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      slot_len_q <= '0;
      used_q     <= '0;
      next_ch_q  <= '0;
      pulse_on_q <= 1'b0;
      in_sync_q  <= 1'b1;
    end else begin
      tick_q     <= tick_d;
      slot_len_q <= slot_len_d;
      used_q     <= used_d;
      next_ch_q  <= next_ch_d;
      pulse_on_q <= pulse_on_d;
      in_sync_q  <= in_sync_d;
    end
  end

  // Store a slot length that passed the range check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        store_q[i] <= (i % 2 == 1) ? rcppm_pkg::SlotResetOdd : rcppm_pkg::SlotResetEven;
      end
    end else if (do_write) begin
      store_q[wr_addr] <= value_i[rcppm_pkg::SlotW-1:0];
    end
  end

  // Result of the current item
  always_comb begin
    result_o.ppm_level      = !(run_i && pulse_on_q && (tick_q < {6'b0, cfg_i.pulse_width}));
    result_o.write_accepted = do_write;
    result_o.read_value     = ((action_i == rcppm_pkg::ACT_READ) && ({2'b0, channel_index_i} < active))
                            ? rd_data : '0;
    result_o.frame_start    = (action_i == rcppm_pkg::ACT_TICK) && run_i && (tick_q == '0)
                            && pulse_on_q && !in_sync_q && (next_ch_q == 5'd1);
  end

  // While running, a slot always has length and the tick stays inside it
  a_slot_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_i |-> (slot_len_q != '0))
    else $error("running with an empty slot");

  a_tick_in_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_i |-> (tick_q < slot_len_q))
    else $error("tick ran past the slot end");

  a_write_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> (store_q[$past(wr_addr)] == $past(value_i[rcppm_pkg::SlotW-1:0])))
    else $error("accepted write not stored");

endmodule

>>> hw/rtl/rc_ppm_frame_generator.sv
// RC PPM frame generator.
// Input stream: one transfer per item. tuser carries the action (tick, write
// slot, read slot, no operation); tdata carries the channel index and value.
// Each tick advances the pulse timeline by one timebase unit; writes and
// reads touch the 16-entry slot store without moving time.
// Output stream: one transfer per input item with the pin level, read value,
// write flag and frame-start flag.
// The result sits in the output register the cycle after its input transfer.
// Throughput is one item per cycle while the receiver does not stall, as the
// timeline update between the input and the output register is combinational.
// A new item is taken while a result waits, as long as the output register
// is free or being drained in the same cycle; a stalled receiver holds the
// result and stops further input after that one.
// Reset loads the slot store (1200 even, 1500 odd), the registers (8 slots,
// stopped, sync 4500, pulse 300) and empties the output register. Writing
// run_enable from 0 to 1 restarts the train with a pulse-free sync period.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i while idle.
module rc_ppm_frame_generator #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned SLOT_MAX     = 2200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // channel_index[3:0], value[19:4], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // action[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // ppm_level[0], read_value[12:1],
                                       // write_accepted[13], frame_start[14], zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [12:0] cfg_wdata_i
);

  logic [rcppm_pkg::CountW-1:0]     count_q;
  logic                             run_q;
  logic [rcppm_pkg::SyncW-1:0]      sync_q;
  logic [rcppm_pkg::PulseW-1:0]     pulse_q;
  logic                             start;
  logic                             accept;
  logic                             out_valid_q, out_valid_d;
  rcppm_pkg::result_t               out_q;
  rcppm_pkg::result_t               result;
  rcppm_pkg::cfg_t                  cfg;
  rcppm_pkg::reg_index_e            cfg_idx;

  assign cfg_idx = rcppm_pkg::reg_index_e'(cfg_addr_i);
  assign start   = cfg_we_i && (cfg_idx == rcppm_pkg::REG_RUN_ENABLE) && cfg_wdata_i[0] && !run_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= rcppm_pkg::CountReset;
      run_q   <= 1'b0;
      sync_q  <= rcppm_pkg::SyncReset;
      pulse_q <= rcppm_pkg::PulseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        rcppm_pkg::REG_CHANNEL_COUNT: count_q <= cfg_wdata_i[rcppm_pkg::CountW-1:0];
        rcppm_pkg::REG_RUN_ENABLE:    run_q   <= cfg_wdata_i[0];
        rcppm_pkg::REG_SYNC_LENGTH:   sync_q  <= cfg_wdata_i[rcppm_pkg::SyncW-1:0];
        rcppm_pkg::REG_PULSE_WIDTH:   pulse_q <= cfg_wdata_i[rcppm_pkg::PulseW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.channel_count = count_q;
  assign cfg.sync_length   = sync_q;
  assign cfg.pulse_width   = pulse_q;

  // Take a transfer whenever the output register is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rcppm_engine #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SLOT_MAX     (SLOT_MAX)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_en_i       (accept),
    .action_i        (rcppm_pkg::action_e'(s_axis_tuser_i)),
    .channel_index_i (s_axis_tdata_i[3:0]),
    .value_i         (s_axis_tdata_i[19:4]),
    .cfg_i           (cfg),
    .run_i           (run_q),
    .start_i         (start),
    .result_o        (result)
  );

  // Output register
  assign out_valid_d = accept || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.frame_start, out_q.write_accepted,
                            out_q.read_value, out_q.ppm_level};

endmodule

>>> tb/rc_ppm_frame_generator_tb.sv
module rc_ppm_frame_generator_tb;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned SlotMax     = 2200;
  localparam int unsigned StallLimit  = 2000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_valid   = 1'b0;
  logic [23:0] s_data    = '0;
  logic [1:0]  s_user    = '0;
  logic        m_ready   = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = '0;
  logic [12:0] cfg_wdata = '0;
  logic        s_ready;
  logic        m_valid;
  logic [15:0] m_data;

  bit          calm = 1'b0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  // Pulse timeline mirror
  logic [rcppm_pkg::SlotW-1:0]  slot_mem [MaxChannels];
  logic [rcppm_pkg::TimeW-1:0]  tick_pos;
  logic [rcppm_pkg::TimeW-1:0]  slot_len;
  logic [rcppm_pkg::TimeW-1:0]  used;
  logic [rcppm_pkg::CountW-1:0] next_ch;
  bit                           pulse_on;
  bit                           in_sync;
  bit                           running;
  logic [rcppm_pkg::CountW-1:0] chan_count;
  bit                           run_en;
  logic [rcppm_pkg::SyncW-1:0]  sync_len;
  logic [rcppm_pkg::PulseW-1:0] pulse_len;

  rcppm_pkg::result_t ppm_out_q [$];

  rc_ppm_frame_generator #(
    .MAX_CHANNELS(MaxChannels),
    .SLOT_MAX    (SlotMax)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the timeline: reset, train start, slot end, pin level
  function automatic void reset_timeline();
    for (int i = 0; i < MaxChannels; i++) begin
      slot_mem[i] = i[0] ? rcppm_pkg::SlotResetOdd : rcppm_pkg::SlotResetEven;
    end
    tick_pos   = '0;
    slot_len   = '0;
    used       = '0;
    next_ch    = '0;
    pulse_on   = 1'b0;
    in_sync    = 1'b1;
    running    = 1'b0;
    chan_count = rcppm_pkg::CountReset;
    run_en     = 1'b0;
    sync_len   = rcppm_pkg::SyncReset;
    pulse_len  = rcppm_pkg::PulseReset;
  endfunction

  function automatic int unsigned live_channels();
    return (chan_count < MaxChannels) ? int'(chan_count) : MaxChannels;
  endfunction

  function automatic void begin_train();
    next_ch  = '0;
    used     = '0;
    in_sync  = 1'b1;
    pulse_on = 1'b0;
    tick_pos = '0;
    slot_len = (sync_len == '0) ? 16'd1 : 16'(sync_len);
  endfunction

  function automatic void close_slot();
    int unsigned frame_len;
    logic [rcppm_pkg::SlotW-1:0] stored;
    if (in_sync) begin
      in_sync = 1'b0;
      next_ch = '0;
      used    = '0;
    end
    if (next_ch < live_channels()) begin
      stored   = slot_mem[next_ch[3:0]];
      slot_len = (stored == '0) ? 16'd1 : 16'(stored);
      used     = used + 16'(stored);
      next_ch  = next_ch + 5'd1;
    end else begin
      frame_len = SlotMax * live_channels() + sync_len;
      if (frame_len > 65535) frame_len = 65535;
      in_sync  = 1'b1;
      slot_len = (frame_len > used) ? 16'(frame_len - used) : 16'd1;
    end
    pulse_on = 1'b1;
  endfunction

  function automatic logic pin_level();
    if (!running) return 1'b1;
    return (pulse_on && tick_pos < 16'(pulse_len)) ? 1'b0 : 1'b1;
  endfunction

  function automatic void apply_reg(rcppm_pkg::reg_index_e r,
                                    logic [rcppm_pkg::CfgW-1:0] v);
    case (r)
      rcppm_pkg::REG_CHANNEL_COUNT: chan_count = v[rcppm_pkg::CountW-1:0];
      rcppm_pkg::REG_RUN_ENABLE: begin
        if (v[0] && !run_en) begin_train();
        run_en  = v[0];
        running = v[0];
      end
      rcppm_pkg::REG_SYNC_LENGTH:   sync_len  = v[rcppm_pkg::SyncW-1:0];
      default:                      pulse_len = v[rcppm_pkg::PulseW-1:0];
    endcase
  endfunction

  // Advance the mirror by one item and return the result it produces
  function automatic rcppm_pkg::result_t ppm_step(rcppm_pkg::action_e act,
                                                  logic [rcppm_pkg::IndexW-1:0] idx,
                                                  logic [rcppm_pkg::ValueW-1:0] val);
    rcppm_pkg::result_t r;
    r = '0;
    r.ppm_level = pin_level();
    case (act)
      rcppm_pkg::ACT_TICK: begin
        if (running) begin
          if (tick_pos == '0 && pulse_on && !in_sync && next_ch == 5'd1) begin
            r.frame_start = 1'b1;
          end
          tick_pos = tick_pos + 16'd1;
          if (tick_pos >= slot_len) begin
            tick_pos = '0;
            close_slot();
          end
        end
      end
      rcppm_pkg::ACT_WRITE: begin
        if (val > rcppm_pkg::WriteMin && val < SlotMax) begin
          slot_mem[idx]    = val[rcppm_pkg::SlotW-1:0];
          r.write_accepted = 1'b1;
        end
      end
      rcppm_pkg::ACT_READ: begin
        if (idx < live_channels()) r.read_value = slot_mem[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Compare one output transfer with the oldest prediction
  task automatic check_result(input rcppm_pkg::result_t got);
    rcppm_pkg::result_t want;
    if (ppm_out_q.size() == 0) begin
      report_mismatch("unexpected result", int'(got), 0);
    end else begin
      want = ppm_out_q.pop_front();
      if (got.ppm_level != want.ppm_level)
        report_mismatch("ppm_level", got.ppm_level, want.ppm_level);
      if (got.read_value != want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.write_accepted != want.write_accepted)
        report_mismatch("write_accepted", got.write_accepted, want.write_accepted);
      if (got.frame_start != want.frame_start)
        report_mismatch("frame_start", got.frame_start, want.frame_start);
    end
  endtask

  // Output side: take transfers and stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) check_result(rcppm_pkg::result_t'(m_data[14:0]));
    m_ready <= calm || ($urandom_range(99) >= 11);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one item, with a random gap ahead of it
  task automatic send_item(input rcppm_pkg::action_e act,
                           input logic [rcppm_pkg::IndexW-1:0] idx,
                           input logic [rcppm_pkg::ValueW-1:0] val);
    while (!calm && $urandom_range(99) < 11) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= {4'b0, val, idx};
    do @(posedge clk_i); while (!s_ready);
    ppm_out_q.push_back(ppm_step(act, idx, val));
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    s_valid <= 1'b0;
    while (ppm_out_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input rcppm_pkg::reg_index_e r,
                           input logic [rcppm_pkg::CfgW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk_i);
    apply_reg(r, v);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_item(input int unsigned tick_pct);
    int unsigned roll;
    logic [rcppm_pkg::ValueW-1:0] val;
    roll = $urandom_range(99);
    val  = ($urandom_range(3) != 0) ? 16'($urandom_range(2199, 801))
                                    : 16'($urandom_range(65535));
    if (roll < tick_pct)
      send_item(rcppm_pkg::ACT_TICK, 4'($urandom_range(15)), 16'($urandom_range(65535)));
    else if (roll < tick_pct + (100 - tick_pct) * 2 / 5)
      send_item(rcppm_pkg::ACT_WRITE, 4'($urandom_range(15)), val);
    else if (roll < tick_pct + (100 - tick_pct) * 4 / 5)
      send_item(rcppm_pkg::ACT_READ, 4'($urandom_range(15)), 16'($urandom_range(65535)));
    else
      send_item(rcppm_pkg::ACT_NOP, 4'($urandom_range(15)), 16'($urandom_range(65535)));
  endtask

  // Store reads and writes with the train stopped, range edges included
  task automatic test_slot_store();
    send_item(rcppm_pkg::ACT_READ, 4'd0, 16'd0);
    send_item(rcppm_pkg::ACT_READ, 4'd1, 16'hFFFF);
    send_item(rcppm_pkg::ACT_READ, 4'd7, 16'd0);
    send_item(rcppm_pkg::ACT_READ, 4'd8, 16'd0);
    send_item(rcppm_pkg::ACT_READ, 4'd15, 16'd0);
    send_item(rcppm_pkg::ACT_WRITE, 4'd0, 16'd800);
    send_item(rcppm_pkg::ACT_WRITE, 4'd0, 16'd801);
    send_item(rcppm_pkg::ACT_WRITE, 4'd1, 16'd2199);
    send_item(rcppm_pkg::ACT_WRITE, 4'd2, 16'd2200);
    send_item(rcppm_pkg::ACT_WRITE, 4'd3, 16'd0);
    send_item(rcppm_pkg::ACT_WRITE, 4'd4, 16'hFFFF);
    send_item(rcppm_pkg::ACT_WRITE, 4'd15, 16'd1000);
    send_item(rcppm_pkg::ACT_READ, 4'd0, 16'd0);
    send_item(rcppm_pkg::ACT_READ, 4'd1, 16'd0);
    send_item(rcppm_pkg::ACT_TICK, 4'd0, 16'd0);
    send_item(rcppm_pkg::ACT_NOP, 4'hF, 16'hFFFF);
    settle();
  endtask

  // Channel count above the store depth and zero channels
  task automatic test_count_limits();
    write_reg(rcppm_pkg::REG_CHANNEL_COUNT, 13'd31);
    send_item(rcppm_pkg::ACT_READ, 4'd15, 16'd0);
    settle();
    write_reg(rcppm_pkg::REG_CHANNEL_COUNT, 13'd0);
    send_item(rcppm_pkg::ACT_READ, 4'd0, 16'd0);
    settle();
  endtask

  // Start, stop, restart and a repeated enable without restart
  task automatic test_run_control();
    write_reg(rcppm_pkg::REG_CHANNEL_COUNT, 13'd1);
    write_reg(rcppm_pkg::REG_SYNC_LENGTH, 13'd0);
    write_reg(rcppm_pkg::REG_PULSE_WIDTH, 13'd1);
    write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd1);
    repeat (3) send_item(rcppm_pkg::ACT_TICK, 4'd0, 16'd0);
    settle();
    write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd0);
    send_item(rcppm_pkg::ACT_TICK, 4'd0, 16'd0);
    settle();
    write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd1);
    repeat (2) send_item(rcppm_pkg::ACT_TICK, 4'd0, 16'd0);
    settle();
    write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd1);
    send_item(rcppm_pkg::ACT_TICK, 4'd0, 16'd0);
    settle();
  endtask

  // Train start into the first channel slot, pulse ending inside the slot
  task automatic test_frame_timeline();
    write_reg(rcppm_pkg::REG_CHANNEL_COUNT, 13'd1);
    write_reg(rcppm_pkg::REG_SYNC_LENGTH, 13'd0);
    write_reg(rcppm_pkg::REG_PULSE_WIDTH, 13'd60);
    write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd0);
    write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd1);
    calm = 1'b1;
    for (int i = 0; i < 160; i++) begin
      if (i == 100) calm = 1'b0;
      send_random_item(97);
    end
    settle();
  endtask

  // Random items over a range of settings, extremes among them
  task automatic test_random_mix();
    logic [rcppm_pkg::CfgW-1:0] cnt_set   [6] = '{13'd0, 13'd0, 13'd16, 13'd31, 13'd1, 13'd0};
    logic [rcppm_pkg::CfgW-1:0] sync_set  [6] = '{13'd3, 13'd7, 13'd8000, 13'd1000, 13'd1,
                                                  13'd8191};
    logic [rcppm_pkg::CfgW-1:0] pulse_set [6] = '{13'd1, 13'd0, 13'd700, 13'd100, 13'd1023,
                                                  13'd2};
    for (int p = 0; p < 6; p++) begin
      write_reg(rcppm_pkg::REG_CHANNEL_COUNT, cnt_set[p]);
      write_reg(rcppm_pkg::REG_SYNC_LENGTH, sync_set[p]);
      write_reg(rcppm_pkg::REG_PULSE_WIDTH, pulse_set[p]);
      if ($urandom_range(1) != 0) write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd0);
      write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd1);
      for (int i = 0; i < 50; i++) send_random_item(70);
      settle();
    end
    // Stopped train with random traffic
    write_reg(rcppm_pkg::REG_RUN_ENABLE, 13'd0);
    for (int i = 0; i < 20; i++) send_random_item(50);
    settle();
  endtask

  initial begin
    reset_timeline();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_slot_store();
    test_count_limits();
    test_run_control();
    test_frame_timeline();
    test_random_mix();
    repeat (4) @(posedge clk_i);
    if (err_count == 0 && ppm_out_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rcppm_pkg.sv
hw/rtl/rcppm_engine.sv
hw/rtl/rc_ppm_frame_generator.sv
tb/rc_ppm_frame_generator_tb.sv
